FILE: hdl/voxel_volume_rotation_defines.svh
// Assertion macros for the voxel volume rotation block.
// Included by the top level; no other dependencies.
`ifndef VOXEL_VOLUME_ROTATION_DEFINES_SVH
`define VOXEL_VOLUME_ROTATION_DEFINES_SVH

// same-cycle implication
`define VVR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vvr assertion failed");

// next-cycle implication
`define VVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vvr assertion failed");

`endif

FILE: hdl/vvr_pkg.sv
// Shared types, constants and orientation tables for the voxel rotation block.
// No dependencies.
package vvr_pkg;

   localparam int MaxDim     = 32;
   localparam int CoordW     = $clog2(MaxDim);
   localparam int DimW       = CoordW + 1;
   localparam int AddrW      = 3 * CoordW;
   localparam int MemDepth   = 1 << AddrW;
   localparam int VoxelW     = 8;
   localparam int UpW        = 3;
   localparam int SpinW      = 2;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 6;
   localparam int QueueDepth = 2;
   localparam int QIdxW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCntW      = $clog2(QueueDepth + 1);
   localparam int NumFaces   = 6;

   localparam logic [DimW-1:0]  DimReset  = DimW'(32);
   localparam logic [DimW-1:0]  DimMax    = DimW'(MaxDim);
   localparam logic [UpW-1:0]   FaceCount = UpW'(NumFaces);

   typedef enum logic [0:0] {
      KIND_STORE = 1'b0,
      KIND_READ  = 1'b1
   } kind_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SIZE_X  = 3'd0,
      CSR_SIZE_Y  = 3'd1,
      CSR_SIZE_Z  = 3'd2,
      CSR_UP_FACE = 3'd3,
      CSR_SPIN    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // up face -> destination axis that carries the source y axis, and its mirror
   localparam axis_type FaceAxis [NumFaces] = '{AXIS_Y, AXIS_Y, AXIS_X, AXIS_X, AXIS_Z, AXIS_Z};
   localparam logic     FaceNeg  [NumFaces] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

   // spin -> source axis and mirror for the two remaining destination axes
   localparam axis_type TurnAxis [4][2] = '{'{AXIS_X, AXIS_Z}, '{AXIS_Z, AXIS_X},
                                            '{AXIS_X, AXIS_Z}, '{AXIS_Z, AXIS_X}};
   localparam logic     TurnNeg  [4][2] = '{'{1'b0, 1'b0}, '{1'b1, 1'b0},
                                            '{1'b1, 1'b1}, '{1'b0, 1'b1}};

   typedef struct packed {
      logic              is_read;
      logic              oor;
      logic [AddrW-1:0]  addr;
      logic [VoxelW-1:0] voxel;
      logic [DimW-1:0]   ext_x;
      logic [DimW-1:0]   ext_y;
      logic [DimW-1:0]   ext_z;
   } entry_type;

   typedef struct packed {
      logic             full;
      logic             empty;
      logic [QCntW-1:0] count;
   } queue_status_type;

   function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] s);
      return (s > DimMax) ? DimMax : s;
   endfunction

endpackage

FILE: hdl/vvr_front.sv
// Front end: configuration registers, item classification and rotation mapping.
// Depends on vvr_pkg.
module vvr_front
   import vvr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxW-1:0]     csr_index,
   input  logic [CsrDataW-1:0]    csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic [CoordW-1:0]      req_coord_x,
   input  logic [CoordW-1:0]      req_coord_y,
   input  logic [CoordW-1:0]      req_coord_z,
   input  logic [VoxelW-1:0]      req_voxel_in,
   input  queue_status_type       q_status,
   output logic                   push_valid,
   output entry_type              push_entry
);

   logic [DimW-1:0]   size_x_ff, size_x_in;
   logic [DimW-1:0]   size_y_ff, size_y_in;
   logic [DimW-1:0]   size_z_ff, size_z_in;
   logic [UpW-1:0]    up_face_ff, up_face_in;
   logic [SpinW-1:0]  spin_ff, spin_in;

   logic [DimW-1:0]   dim [3];
   logic [DimW-1:0]   nd [3];
   logic [CoordW-1:0] crd [3];
   logic [CoordW-1:0] src [3];
   axis_type          ax [3];
   logic              neg [3];
   logic [UpW-1:0]    face;
   axis_type          up_axis;
   axis_type          side0, side1;
   logic [DimW-1:0]   mirrored;
   logic              outside;
   logic              in_store;

   assign csr_ready = 1'b1;

   always_comb begin
      size_x_in  = size_x_ff;
      size_y_in  = size_y_ff;
      size_z_in  = size_z_ff;
      up_face_in = up_face_ff;
      spin_in    = spin_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SIZE_X:  size_x_in  = csr_wdata[DimW-1:0];
            CSR_SIZE_Y:  size_y_in  = csr_wdata[DimW-1:0];
            CSR_SIZE_Z:  size_z_in  = csr_wdata[DimW-1:0];
            CSR_UP_FACE: up_face_in = csr_wdata[UpW-1:0];
            CSR_SPIN:    spin_in    = csr_wdata[SpinW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff  <= DimReset;
         size_y_ff  <= DimReset;
         size_z_ff  <= DimReset;
         up_face_ff <= '0;
         spin_ff    <= '0;
      end else begin
         size_x_ff  <= size_x_in;
         size_y_ff  <= size_y_in;
         size_z_ff  <= size_z_in;
         up_face_ff <= up_face_in;
         spin_ff    <= spin_in;
      end
   end

   always_comb begin
      dim[0] = clamp_dim(size_x_ff);
      dim[1] = clamp_dim(size_y_ff);
      dim[2] = clamp_dim(size_z_ff);
      crd[0] = req_coord_x;
      crd[1] = req_coord_y;
      crd[2] = req_coord_z;

      face    = (up_face_ff >= FaceCount) ? up_face_ff - FaceCount : up_face_ff;
      up_axis = FaceAxis[face];
      unique case (up_axis)
         AXIS_X:  begin side0 = AXIS_Y; side1 = AXIS_Z; end
         AXIS_Y:  begin side0 = AXIS_X; side1 = AXIS_Z; end
         default: begin side0 = AXIS_X; side1 = AXIS_Y; end
      endcase

      for (int w = 0; w < 3; w++) begin
         ax[w]  = AXIS_Y;
         neg[w] = 1'b0;
      end
      ax[up_axis]  = AXIS_Y;
      neg[up_axis] = FaceNeg[face];
      ax[side0]    = TurnAxis[spin_ff][0];
      neg[side0]   = TurnNeg[spin_ff][0];
      ax[side1]    = TurnAxis[spin_ff][1];
      neg[side1]   = TurnNeg[spin_ff][1];

      outside  = 1'b0;
      in_store = 1'b1;
      mirrored = '0;
      for (int w = 0; w < 3; w++) begin
         src[w] = '0;
      end
      for (int w = 0; w < 3; w++) begin
         nd[w] = dim[ax[w]];
         if ({1'b0, crd[w]} >= nd[w]) begin
            outside = 1'b1;
         end
         if ({1'b0, crd[w]} >= dim[w]) begin
            in_store = 1'b0;
         end
      end
      for (int w = 0; w < 3; w++) begin
         mirrored    = nd[w] - DimW'(1) - {1'b0, crd[w]};
         src[ax[w]]  = neg[w] ? mirrored[CoordW-1:0] : crd[w];
      end
   end

   assign req_ready  = !q_status.full;
   assign push_valid = req_valid && req_ready && ((req_kind == KIND_READ) || in_store);

   always_comb begin
      push_entry.is_read = (req_kind == KIND_READ);
      push_entry.oor     = outside;
      push_entry.voxel   = req_voxel_in;
      push_entry.ext_x   = nd[0];
      push_entry.ext_y   = nd[1];
      push_entry.ext_z   = nd[2];
      if (req_kind == KIND_READ) begin
         push_entry.addr = {src[2], src[1], src[0]};
      end else begin
         push_entry.addr = {req_coord_z, req_coord_y, req_coord_x};
      end
   end

endmodule

FILE: hdl/vvr_queue.sv
// Short queue between front end and back end.
// Depends on vvr_pkg.
module vvr_queue
   import vvr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        pop_entry,
   output queue_status_type q_status
);

   entry_type        entries_ff [QueueDepth];
   logic [QIdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QIdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff, count_in;

   function automatic logic [QIdxW-1:0] next_ptr(input logic [QIdxW-1:0] p);
      return (p == QIdxW'(QueueDepth - 1)) ? '0 : p + QIdxW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push_valid ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + QCntW'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry      = entries_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QCntW'(QueueDepth));
   assign q_status.empty = (count_ff == '0);
   assign q_status.count = count_ff;

endmodule

FILE: hdl/vvr_back.sv
// Back end: voxel memory access and result register.
// Depends on vvr_pkg.
module vvr_back
   import vvr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  queue_status_type  q_status,
   input  entry_type         pop_entry,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [VoxelW-1:0] rsp_voxel_out,
   output logic              rsp_out_of_range,
   output logic [DimW-1:0]   rsp_rotated_x,
   output logic [DimW-1:0]   rsp_rotated_y,
   output logic [DimW-1:0]   rsp_rotated_z
);

   logic [VoxelW-1:0] voxel_mem_ff [MemDepth];
   logic [VoxelW-1:0] rd_data_ff;
   logic              pend_ff, pend_in;
   logic              pend_oor_ff;
   logic [DimW-1:0]   pend_ext_x_ff, pend_ext_y_ff, pend_ext_z_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VoxelW-1:0] rsp_voxel_ff;
   logic              rsp_oor_ff;
   logic [DimW-1:0]   rsp_ext_x_ff, rsp_ext_y_ff, rsp_ext_z_ff;
   logic              slot_free;
   logic              mem_we, mem_re;

   // a read may issue only when its result lands in an empty output register
   assign slot_free = !pend_ff && (!rsp_valid_ff || rsp_ready);
   assign pop       = !q_status.empty && (!pop_entry.is_read || slot_free);
   assign mem_we    = pop && !pop_entry.is_read;
   assign mem_re    = pop && pop_entry.is_read;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         voxel_mem_ff[pop_entry.addr] <= pop_entry.voxel;
      end
      if (mem_re) begin
         rd_data_ff <= voxel_mem_ff[pop_entry.addr];
      end
   end

   always_comb begin
      pend_in      = mem_re;
      rsp_valid_in = rsp_valid_ff;
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         pend_oor_ff   <= pop_entry.oor;
         pend_ext_x_ff <= pop_entry.ext_x;
         pend_ext_y_ff <= pop_entry.ext_y;
         pend_ext_z_ff <= pop_entry.ext_z;
      end
      if (pend_ff) begin
         rsp_voxel_ff <= pend_oor_ff ? '0 : rd_data_ff;
         rsp_oor_ff   <= pend_oor_ff;
         rsp_ext_x_ff <= pend_ext_x_ff;
         rsp_ext_y_ff <= pend_ext_y_ff;
         rsp_ext_z_ff <= pend_ext_z_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_voxel_out    = rsp_voxel_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_rotated_x    = rsp_ext_x_ff;
   assign rsp_rotated_y    = rsp_ext_y_ff;
   assign rsp_rotated_z    = rsp_ext_z_ff;

endmodule

FILE: hdl/voxel_volume_rotation.sv
// Top level of the voxel volume rotation block: front end, queue, back end.
// Depends on vvr_pkg, vvr_front, vvr_queue, vvr_back and the defines header.
//
//   Channel  Direction  Handshake              Carries
//   req_     in         req_valid/req_ready    kind, coord_x/y/z, voxel_in
//   rsp_     out        rsp_valid/rsp_ready    voxel_out, out_of_range, rotated_x/y/z
//   csr_     in         csr_valid/csr_ready    csr_index, csr_wdata
//
// A read item passes through the queue, the read data register and the output
// register before it shows up on rsp_; stores give no item.
// Stores retire one per cycle unless a read waits at the queue head; a read issues
// only after the previous read's data has moved on into an empty output register.
// Reset is synchronous and clears control state only; the voxel memory is not cleared.
// req_ready drops only while the two-entry queue is full; csr_ready is always high.
`include "voxel_volume_rotation_defines.svh"

module voxel_volume_rotation
   import vvr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [CoordW-1:0]   req_coord_x,
   input  logic [CoordW-1:0]   req_coord_y,
   input  logic [CoordW-1:0]   req_coord_z,
   input  logic [VoxelW-1:0]   req_voxel_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VoxelW-1:0]   rsp_voxel_out,
   output logic                rsp_out_of_range,
   output logic [DimW-1:0]     rsp_rotated_x,
   output logic [DimW-1:0]     rsp_rotated_y,
   output logic [DimW-1:0]     rsp_rotated_z
);

   queue_status_type q_status;
   logic             push_valid;
   entry_type        push_entry;
   logic             pop;
   entry_type        pop_entry;

   vvr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_coord_x  (req_coord_x),
      .req_coord_y  (req_coord_y),
      .req_coord_z  (req_coord_z),
      .req_voxel_in (req_voxel_in),
      .q_status     (q_status),
      .push_valid   (push_valid),
      .push_entry   (push_entry)
   );

   vvr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   vvr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .pop_entry        (pop_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_voxel_out    (rsp_voxel_out),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_rotated_x    (rsp_rotated_x),
      .rsp_rotated_y    (rsp_rotated_y),
      .rsp_rotated_z    (rsp_rotated_z)
   );

   `VVR_ASSERT_NOW(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range, rsp_voxel_out == '0)
   `VVR_ASSERT_NOW(a_inrange_extents, clock, reset, rsp_valid && !rsp_out_of_range, (rsp_rotated_x != '0) && (rsp_rotated_y != '0) && (rsp_rotated_z != '0))
   `VVR_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, q_status.count <= QCntW'(QueueDepth))
   `VVR_ASSERT_NEXT(a_push_when_full, clock, reset, q_status.full && !pop, !push_valid || (q_status.count < QCntW'(QueueDepth)))

endmodule
